// File: rtl/clpc_pkg.sv
// clpc_pkg: shared widths, digit counts and issuer class codes for the
// card prefix / Luhn check block. No dependencies.

package clpc_pkg;

   // Input field width and the decimal digits it can hold (2^54 < 10^17)
   localparam int CARD_WIDTH  = 54;
   localparam int NUM_DIGITS  = 17;
   localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int CLASS_WIDTH = 2;

   // Default for the largest accepted number of decimal digits
   localparam int MAX_DIGITS_DEFAULT = 16;

   // Issuer class codes
   localparam logic [CLASS_WIDTH-1:0] CLASS_INVALID = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_FIFTEEN = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_SIXTEEN = 2'd2;
   localparam logic [CLASS_WIDTH-1:0] CLASS_LEAD4   = 2'd3;

   // One conversion cell's contents: BCD digits so far and the binary bits left
   typedef struct packed {
      logic                  valid;
      logic [BCD_WIDTH-1:0]  bcd;
      logic [CARD_WIDTH-1:0] bin;
   } cell_type;

endpackage

// File: rtl/clpc_dd_cell.sv
// clpc_dd_cell: one shift-and-add-3 cell of the binary to BCD conversion row.
// Each cell consumes one binary bit, MSB first. Depends on clpc_pkg.

module clpc_dd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  clpc_pkg::cell_type cell_i,
   output clpc_pkg::cell_type cell_o
);

   logic [clpc_pkg::BCD_WIDTH-1:0]  adjusted;
   logic                            valid_ff;
   logic [clpc_pkg::BCD_WIDTH-1:0]  bcd_ff;
   logic [clpc_pkg::BCD_WIDTH-1:0]  bcd_in;
   logic [clpc_pkg::CARD_WIDTH-1:0] bin_ff;
   logic [clpc_pkg::CARD_WIDTH-1:0] bin_in;

   // Add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      adjusted = cell_i.bcd;
      for (int d = 0; d < clpc_pkg::NUM_DIGITS; d++) begin
         if (cell_i.bcd[4*d +: 4] >= 4'd5) begin
            adjusted[4*d +: 4] = cell_i.bcd[4*d +: 4] + 4'd3;
         end
      end
      bcd_in = {adjusted[clpc_pkg::BCD_WIDTH-2:0], cell_i.bin[clpc_pkg::CARD_WIDTH-1]};
      bin_in = {cell_i.bin[clpc_pkg::CARD_WIDTH-2:0], 1'b0};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_i.valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (enable) begin
         bcd_ff <= bcd_in;
         bin_ff <= bin_in;
      end
   end

   assign cell_o.valid = valid_ff;
   assign cell_o.bcd   = bcd_ff;
   assign cell_o.bin   = bin_ff;

endmodule

// File: rtl/clpc_luhn_stage.sv
// clpc_luhn_stage: Luhn digit sum, range check and issuer prefix match over
// the converted BCD digits; two register stages, the second drives rsp_.
// Depends on clpc_pkg.

module clpc_luhn_stage #(
   parameter int MaxDigits = clpc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  clpc_pkg::cell_type                 cell_i,
   output logic                               valid_o,
   output logic [clpc_pkg::CLASS_WIDTH-1:0]   issuer_class_o,
   output logic                               checksum_ok_o
);

   // Sum of 17 digits is at most 153
   localparam int HalfDigits = clpc_pkg::NUM_DIGITS / 2;

   logic [3:0] digit [clpc_pkg::NUM_DIGITS];

   logic [6:0] lo_sum_in;
   logic [6:0] hi_sum_in;
   logic [clpc_pkg::CLASS_WIDTH-1:0] class_in;
   logic       range_in;

   logic       s1_valid_ff;
   logic [6:0] s1_lo_ff;
   logic [6:0] s1_hi_ff;
   logic [clpc_pkg::CLASS_WIDTH-1:0] s1_class_ff;
   logic       s1_range_ff;

   logic [7:0] total;
   logic       ok_in;

   logic       valid_ff;
   logic [clpc_pkg::CLASS_WIDTH-1:0] class_ff;
   logic       ok_ff;

   // Luhn weight: every second digit from the right is doubled, minus 9 above 9
   function automatic logic [3:0] luhn_value(input logic [3:0] d, input logic odd_pos);
      logic [4:0] dbl;
      dbl = {d, 1'b0};
      if (!odd_pos) begin
         return d;
      end else if (dbl > 5'd9) begin
         return 4'(dbl - 5'd9);
      end else begin
         return dbl[3:0];
      end
   endfunction

   // Remainder by 10 of a sum below 160, by conditional subtraction
   function automatic logic [3:0] mod10(input logic [7:0] s);
      logic [7:0] r;
      r = s;
      if (r >= 8'd80) r = r - 8'd80;
      if (r >= 8'd40) r = r - 8'd40;
      if (r >= 8'd20) r = r - 8'd20;
      if (r >= 8'd10) r = r - 8'd10;
      return r[3:0];
   endfunction

   always_comb begin
      for (int i = 0; i < clpc_pkg::NUM_DIGITS; i++) begin
         digit[i] = cell_i.bcd[4*i +: 4];
      end
   end

   // Stage 1: half sums, digit count limit, prefix match
   always_comb begin
      lo_sum_in = '0;
      hi_sum_in = '0;
      range_in  = 1'b1;
      for (int i = 0; i < clpc_pkg::NUM_DIGITS; i++) begin
         if (i < HalfDigits) begin
            lo_sum_in = lo_sum_in + 7'(luhn_value(digit[i], 1'(i % 2)));
         end else begin
            hi_sum_in = hi_sum_in + 7'(luhn_value(digit[i], 1'(i % 2)));
         end
         if (i >= MaxDigits && digit[i] != 4'd0) begin
            range_in = 1'b0;
         end
      end

      // Fifteen digits 34/37, sixteen digits 51-55, leading 4 at 13 or 16 digits
      if (digit[16] == 4'd0 && digit[15] == 4'd0 && digit[14] == 4'd3 &&
          (digit[13] == 4'd4 || digit[13] == 4'd7)) begin
         class_in = clpc_pkg::CLASS_FIFTEEN;
      end else if (digit[16] == 4'd0 && digit[15] == 4'd5 &&
                   digit[14] >= 4'd1 && digit[14] <= 4'd5) begin
         class_in = clpc_pkg::CLASS_SIXTEEN;
      end else if ((digit[16] == 4'd0 && digit[15] == 4'd4) ||
                   (digit[16] == 4'd0 && digit[15] == 4'd0 && digit[14] == 4'd0 &&
                    digit[13] == 4'd0 && digit[12] == 4'd4)) begin
         class_in = clpc_pkg::CLASS_LEAD4;
      end else begin
         class_in = clpc_pkg::CLASS_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= cell_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_lo_ff    <= lo_sum_in;
         s1_hi_ff    <= hi_sum_in;
         s1_class_ff <= class_in;
         s1_range_ff <= range_in;
      end
   end

   // Stage 2: total, mod 10, final verdict
   assign total = 8'(s1_lo_ff) + 8'(s1_hi_ff);
   assign ok_in = s1_range_ff && (mod10(total) == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ok_ff    <= ok_in;
         class_ff <= ok_in ? s1_class_ff : clpc_pkg::CLASS_INVALID;
      end
   end

   assign valid_o        = valid_ff;
   assign issuer_class_o = class_ff;
   assign checksum_ok_o  = ok_ff;

endmodule

// File: rtl/card_prefix_luhn_check.sv
// card_prefix_luhn_check: top level; a row of BCD conversion cells followed
// by the Luhn / prefix stage. Depends on clpc_pkg, clpc_dd_cell, clpc_luhn_stage.
//
// Usage:
//   Input channel req_valid / req_ready carries req_card_number, an unsigned
//   binary card number. Result channel rsp_valid / rsp_ready carries
//   rsp_issuer_class (0 invalid, 1 fifteen-digit 34/37, 2 sixteen-digit
//   51-55, 3 leading 4 at 13 or 16 digits) and rsp_checksum_ok (Luhn sum
//   is a multiple of 10). Numbers of 10^MAX_DIGITS or more give 0 / 0.
//   Exactly one result per item, in order.
//   Each accepted item passes one conversion cell per input bit, then the
//   sum and classification registers of the Luhn stage, to rsp_valid.
//   Throughput: one item per cycle while the pipe is not held.
//   The whole pipe advances together; it holds while a result is shown and
//   rsp_ready is low, so req_ready falls then and rises as soon as the
//   result is taken. Reset (synchronous) empties the pipe; no items are lost
//   afterward.

module card_prefix_luhn_check #(
   parameter int MAX_DIGITS = clpc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [clpc_pkg::CARD_WIDTH-1:0]   req_card_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [clpc_pkg::CLASS_WIDTH-1:0]  rsp_issuer_class,
   output logic                              rsp_checksum_ok
);

   clpc_pkg::cell_type chain [clpc_pkg::CARD_WIDTH+1];
   logic advance;

   // Pipe moves when the output register is empty or being drained
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Row input: new item, empty BCD digits, all binary bits left
   assign chain[0] = {req_valid, {clpc_pkg::BCD_WIDTH{1'b0}}, req_card_number};

   // Conversion row, one cell per input bit
   for (genvar g = 0; g < clpc_pkg::CARD_WIDTH; g++) begin : g_cell
      clpc_dd_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
   end

   clpc_luhn_stage #(
      .MaxDigits (MAX_DIGITS)
   ) u_luhn (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .cell_i         (chain[clpc_pkg::CARD_WIDTH]),
      .valid_o        (rsp_valid),
      .issuer_class_o (rsp_issuer_class),
      .checksum_ok_o  (rsp_checksum_ok)
   );

   // A class is only reported with a passing checksum
   a_class_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_issuer_class != clpc_pkg::CLASS_INVALID) |-> rsp_checksum_ok)
      else $error("issuer class reported without checksum");

   // Input is held off only by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // An accepted item enters the first cell
   a_enter_row: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> chain[1].valid)
      else $error("accepted item missing from first cell");

   // A stalled pipe keeps its first cell
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[1].valid))
      else $error("first cell changed during stall");

endmodule

// File: verif/card_prefix_luhn_check_test.sv
// Self-checking testbench for card_prefix_luhn_check: drives card numbers,
// predicts issuer class and Luhn verdict, and compares each result in order.
// Depends on clpc_pkg and the card_prefix_luhn_check RTL.
`timescale 1ns / 1ps

module card_prefix_luhn_check_test;

   localparam int CARD_WIDTH  = clpc_pkg::CARD_WIDTH;
   localparam int CLASS_WIDTH = clpc_pkg::CLASS_WIDTH;
   localparam int MAX_DIGITS = 16;
   // 10^MAX_DIGITS: anything at or above is rejected outright
   localparam longint unsigned DIGIT_LIMIT = 64'd10_000_000_000_000_000;
   localparam longint unsigned POW10_12    = 64'd1_000_000_000_000;
   localparam longint unsigned POW10_13    = 64'd10_000_000_000_000;
   localparam longint unsigned POW10_14    = 64'd100_000_000_000_000;
   localparam longint unsigned POW10_15    = 64'd1_000_000_000_000_000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [CLASS_WIDTH-1:0] issuer_class;
      logic                   checksum_ok;
   } card_verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CARD_WIDTH-1:0]  req_card_number = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CLASS_WIDTH-1:0] rsp_issuer_class;
   logic                   rsp_checksum_ok;

   logic [CARD_WIDTH-1:0] pending_cards[$];
   card_verdict_type      expected_verdicts[$];
   int                    error_count = 0;
   int                    cycle_count = 0;

   card_prefix_luhn_check #(
      .MAX_DIGITS(MAX_DIGITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_card_number(req_card_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_issuer_class(rsp_issuer_class),
      .rsp_checksum_ok(rsp_checksum_ok)
   );

   always #5 clock = ~clock;

   // Luhn over 20 digit positions, doubling every second one from the right
   function automatic bit luhn_passes(input longint unsigned number);
      longint unsigned rest;
      int unsigned     total;
      int unsigned     digit;
      rest  = number;
      total = 0;
      for (int pos = 0; pos < 20; pos++) begin
         digit = int'(rest % 10);
         rest  = rest / 10;
         if (pos % 2 == 1) begin
            digit = digit * 2;
            if (digit > 9) digit = digit - 9;
         end
         total += digit;
      end
      return (total % 10) == 0;
   endfunction

   function automatic card_verdict_type predict_verdict(input logic [CARD_WIDTH-1:0] card);
      longint unsigned  number;
      longint unsigned  lead15;
      longint unsigned  lead16;
      card_verdict_type verdict;
      number               = 64'(card);
      verdict.issuer_class = clpc_pkg::CLASS_INVALID;
      verdict.checksum_ok  = 1'b0;
      if (number < DIGIT_LIMIT) begin
         verdict.checksum_ok = luhn_passes(number);
         if (verdict.checksum_ok) begin
            lead15 = number / POW10_13;
            lead16 = number / POW10_14;
            if (lead15 == 34 || lead15 == 37)
               verdict.issuer_class = clpc_pkg::CLASS_FIFTEEN;
            else if (lead16 >= 51 && lead16 <= 55)
               verdict.issuer_class = clpc_pkg::CLASS_SIXTEEN;
            else if (number / POW10_15 == 4 || number / POW10_12 == 4)
               verdict.issuer_class = clpc_pkg::CLASS_LEAD4;
         end
      end
      return verdict;
   endfunction

   // Prefix, random middle digits, then a check digit that passes Luhn;
   // flipping bit 0 moves the last digit by one and breaks the sum
   function automatic logic [CARD_WIDTH-1:0] build_card(input longint unsigned prefix,
                                                        input int prefix_len,
                                                        input int total_len,
                                                        input bit break_sum);
      longint unsigned number;
      number = prefix;
      for (int i = prefix_len; i < total_len - 1; i++)
         number = number * 10 + longint'($urandom_range(0, 9));
      number = number * 10;
      for (int d = 0; d < 10; d++) begin
         if (luhn_passes(number + longint'(d))) begin
            number = number + longint'(d);
            break;
         end
      end
      if (break_sum) number = number ^ 64'd1;
      return number[CARD_WIDTH-1:0];
   endfunction

   function automatic logic [CARD_WIDTH-1:0] random_card();
      logic [63:0] raw;
      int          pick;
      int          len;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // well-formed issuer numbers, some with a broken check digit
         case ($urandom_range(0, 3))
            0: return build_card($urandom_range(0, 1) ? 34 : 37, 2, 15, pick >= 55);
            1: return build_card($urandom_range(51, 55), 2, 16, pick >= 55);
            2: return build_card(4, 1, 13, pick >= 55);
            default: return build_card(4, 1, 16, pick >= 55);
         endcase
      end else if (pick < 85) begin
         // arbitrary leading digit and length
         len = $urandom_range(2, 16);
         return build_card($urandom_range(1, 9), 1, len, $urandom_range(0, 3) == 0);
      end else begin
         raw = {$urandom(), $urandom()};
         return raw[CARD_WIDTH-1:0];
      end
   endfunction

   // Random stalls, except for a quiet window with none
   function automatic bit take_break();
      if (cycle_count >= 800 && cycle_count < 1400) return 1'b0;
      return $urandom_range(0, 99) < 10;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Driver: record the expectation for each accepted item, then load the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_verdicts.push_back(predict_verdict(req_card_number));
         if (!req_valid || req_ready) begin
            if (pending_cards.size() > 0 && !take_break()) begin
               req_valid       <= 1'b1;
               req_card_number <= pending_cards.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_monitor
      card_verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_break();
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result: issuer_class %0d checksum_ok %0d",
                      rsp_issuer_class, rsp_checksum_ok);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_issuer_class !== want.issuer_class) begin
                  $error("issuer_class: expected %0d, got %0d",
                         want.issuer_class, rsp_issuer_class);
                  error_count++;
               end
               if (rsp_checksum_ok !== want.checksum_ok) begin
                  $error("checksum_ok: expected %0d, got %0d",
                         want.checksum_ok, rsp_checksum_ok);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      // Directed: range edges, each issuer class, near-miss prefixes and lengths
      pending_cards.push_back('0);
      pending_cards.push_back({CARD_WIDTH{1'b1}});
      pending_cards.push_back(CARD_WIDTH'(DIGIT_LIMIT));
      pending_cards.push_back(CARD_WIDTH'(DIGIT_LIMIT - 1));
      pending_cards.push_back(CARD_WIDTH'(POW10_13));
      pending_cards.push_back(build_card(34, 2, 15, 1'b0));
      pending_cards.push_back(build_card(37, 2, 15, 1'b0));
      pending_cards.push_back(build_card(34, 2, 15, 1'b1));
      pending_cards.push_back(build_card(51, 2, 16, 1'b0));
      pending_cards.push_back(build_card(55, 2, 16, 1'b0));
      pending_cards.push_back(build_card(53, 2, 16, 1'b1));
      pending_cards.push_back(build_card(4, 1, 13, 1'b0));
      pending_cards.push_back(build_card(4, 1, 16, 1'b0));
      pending_cards.push_back(build_card(4, 1, 16, 1'b1));
      pending_cards.push_back(build_card(4, 1, 15, 1'b0));
      pending_cards.push_back(build_card(4, 1, 14, 1'b0));
      pending_cards.push_back(build_card(50, 2, 16, 1'b0));
      pending_cards.push_back(build_card(56, 2, 16, 1'b0));
      pending_cards.push_back(build_card(35, 2, 15, 1'b0));
      pending_cards.push_back(build_card(34, 2, 16, 1'b0));
      pending_cards.push_back(build_card(51, 2, 15, 1'b0));
      pending_cards.push_back(build_card(9, 1, 16, 1'b0));
      pending_cards.push_back(build_card(1, 1, 16, 1'b0));
      for (int i = 0; i < RANDOM_ITEMS; i++)
         pending_cards.push_back(random_card());

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_cards.size() != 0 || req_valid) @(negedge clock);
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
